>>> rtl/bant_pkg.sv
`default_nettype none
package bant_pkg;

    // Sizes
    localparam int MAX_DEPTH  = 8;
    localparam int DEPTH_W    = 4;
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ADDR_W     = 64;
    localparam int WORD_W     = 32;
    localparam int OFF_W      = WORD_W + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_CAPACITY = 1'd1;

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_RESERVE = 2'd1,
        OP_COMMIT  = 2'd2,
        OP_ABANDON = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_ARG     = 3'd1,
        ST_UNBOUND     = 3'd2,
        ST_DEPTH_LIMIT = 3'd3,
        ST_BAD_TXN     = 3'd4,
        ST_OVERFLOW    = 3'd5,
        ST_NO_ROOM     = 3'd6
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  serial;
        logic [DEPTH_W-1:0] depth;
        logic [WORD_W-1:0]  count;
        logic [WORD_W-1:0]  align;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  granted;
        logic [WORD_W-1:0]  nserial;
        logic [DEPTH_W-1:0] ndepth;
        logic [WORD_W-1:0]  coff;
        logic [WORD_W-1:0]  clen;
    } t_result;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] push_serial;
        logic [WORD_W-1:0] push_base;
    } t_stack_cmd;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               empty;
        logic               full;
        logic [WORD_W-1:0]  serial;
        logic [WORD_W-1:0]  base;
    } t_stack_top;

    typedef struct packed {
        logic              cursor_we;
        logic [WORD_W-1:0] cursor;
        logic [ADDR_W:0]   base_cur;
        logic              mark_we;
        logic [WORD_W-1:0] mark;
        logic              counter_inc;
        t_stack_cmd        stack;
    } t_update;

endpackage
`default_nettype wire

>>> rtl/bant_in_if.sv
`default_nettype none
interface bant_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [bant_pkg::WORD_W-1:0]   txn_serial;
    logic [bant_pkg::DEPTH_W-1:0]  txn_depth;
    logic [bant_pkg::WORD_W-1:0]   byte_count;
    logic [bant_pkg::WORD_W-1:0]   alignment;

    modport source (
        output valid, operation, txn_serial, txn_depth, byte_count, alignment,
        input  ready
    );
    modport sink (
        input  valid, operation, txn_serial, txn_depth, byte_count, alignment,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/bant_out_if.sv
`default_nettype none
interface bant_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [bant_pkg::ADDR_W-1:0]   granted_address;
    logic [bant_pkg::WORD_W-1:0]   new_serial;
    logic [bant_pkg::DEPTH_W-1:0]  new_depth;
    logic [bant_pkg::WORD_W-1:0]   clear_offset;
    logic [bant_pkg::WORD_W-1:0]   clear_length;

    modport source (
        output valid, status, granted_address, new_serial, new_depth,
               clear_offset, clear_length,
        input  ready
    );
    modport sink (
        input  valid, status, granted_address, new_serial, new_depth,
               clear_offset, clear_length,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/bant_stack.sv
`default_nettype none
module bant_stack (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bant_pkg::t_stack_cmd i_cmd,
    output bant_pkg::t_stack_top      o_top
);

    logic [bant_pkg::DEPTH_W-1:0] r_depth;
    logic [bant_pkg::WORD_W-1:0]  r_serial [bant_pkg::MAX_DEPTH];
    logic [bant_pkg::WORD_W-1:0]  r_base   [bant_pkg::MAX_DEPTH];
    logic [bant_pkg::IDX_W-1:0]   w_top_idx;
    logic [bant_pkg::IDX_W-1:0]   w_push_idx;
    logic [bant_pkg::DEPTH_W-1:0] w_depth_m1;

    // Locate top of stack and next free slot
    assign w_depth_m1 = r_depth - bant_pkg::DEPTH_W'(1);
    assign w_top_idx  = w_depth_m1[bant_pkg::IDX_W-1:0];
    assign w_push_idx = r_depth[bant_pkg::IDX_W-1:0];

    // Present top entry
    always_comb begin
        o_top.depth  = r_depth;
        o_top.empty  = (r_depth == '0);
        o_top.full   = (r_depth >= bant_pkg::DEPTH_W'(bant_pkg::MAX_DEPTH));
        o_top.serial = r_serial[w_top_idx];
        o_top.base   = r_base[w_top_idx];
    end

    // Track depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + bant_pkg::DEPTH_W'(1);
        end else if (i_cmd.pop) begin
            r_depth <= w_depth_m1;
        end
    end

    // Write pushed entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_serial[w_push_idx] <= i_cmd.push_serial;
            r_base[w_push_idx]   <= i_cmd.push_base;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= bant_pkg::DEPTH_W'(bant_pkg::MAX_DEPTH))
        else $error("stack depth beyond limit");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_top.full && !i_cmd.pop)
        else $error("push on full stack or with pop");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_top.empty)
        else $error("pop on empty stack");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_depth == $past(r_depth) + bant_pkg::DEPTH_W'(1))
        else $error("push did not grow stack");

endmodule
`default_nettype wire

>>> rtl/bant_exec.sv
`default_nettype none
module bant_exec (
    input  wire bant_pkg::t_item              i_item,
    input  wire logic [bant_pkg::ADDR_W-1:0]  i_base_addr,
    input  wire logic [bant_pkg::WORD_W-1:0]  i_capacity,
    input  wire logic [bant_pkg::WORD_W-1:0]  i_cursor,
    input  wire logic [bant_pkg::WORD_W-1:0]  i_mark,
    input  wire logic [bant_pkg::WORD_W-1:0]  i_counter,
    input  wire logic [bant_pkg::ADDR_W:0]    i_base_cur,
    input  wire bant_pkg::t_stack_top         i_top,
    output bant_pkg::t_result                 o_res,
    output bant_pkg::t_update                 o_upd
);

    logic                         w_handle_ok;
    logic                         w_bad_arg;
    logic                         w_unbound;
    logic [bant_pkg::WORD_W-1:0]  w_mask;
    logic [bant_pkg::ADDR_W:0]    w_sum;
    logic                         w_ovf;
    logic [bant_pkg::ADDR_W-1:0]  w_aligned;
    logic [bant_pkg::OFF_W-1:0]   w_off;
    logic [bant_pkg::OFF_W-1:0]   w_end;
    logic                         w_no_room;
    logic [bant_pkg::WORD_W-1:0]  w_reclaim;

    // Check handle against top of stack
    assign w_handle_ok = !i_top.empty && (i_item.depth == i_top.depth)
                         && (i_item.serial == i_top.serial);

    // Check arguments and binding
    assign w_mask    = i_item.align - bant_pkg::WORD_W'(1);
    assign w_bad_arg = (i_item.count == '0) || (i_item.align == '0)
                       || ((i_item.align & w_mask) != '0);
    assign w_unbound = (i_capacity == '0);

    // Align cursor address; carry out of either add is an overflow
    assign w_sum     = {1'b0, i_base_cur[bant_pkg::ADDR_W-1:0]}
                       + {{(bant_pkg::ADDR_W-bant_pkg::WORD_W+1){1'b0}}, w_mask};
    assign w_ovf     = i_base_cur[bant_pkg::ADDR_W] || w_sum[bant_pkg::ADDR_W];
    assign w_aligned = w_sum[bant_pkg::ADDR_W-1:0]
                       & {{(bant_pkg::ADDR_W-bant_pkg::WORD_W){1'b1}}, ~w_mask};

    // Offset stays below twice the word range, so low bits suffice
    assign w_off     = w_aligned[bant_pkg::OFF_W-1:0] - i_base_addr[bant_pkg::OFF_W-1:0];
    assign w_end     = w_off + {2'b00, i_item.count};
    assign w_no_room = (w_end > {2'b00, i_capacity});

    // Rollback point for abandon
    assign w_reclaim = (i_top.base > i_mark) ? i_top.base : i_mark;

    always_comb begin
        o_res        = '0;
        o_res.status = bant_pkg::ST_OK;
        o_upd        = '0;
        case (i_item.op)
            bant_pkg::OP_BEGIN: begin
                if (w_unbound) begin
                    o_res.status = bant_pkg::ST_UNBOUND;
                end else if (i_top.full) begin
                    o_res.status = bant_pkg::ST_DEPTH_LIMIT;
                end else begin
                    o_res.nserial           = i_counter;
                    o_res.ndepth            = i_top.depth + bant_pkg::DEPTH_W'(1);
                    o_upd.counter_inc       = 1'b1;
                    o_upd.stack.push        = 1'b1;
                    o_upd.stack.push_serial = i_counter;
                    o_upd.stack.push_base   = i_cursor;
                end
            end
            bant_pkg::OP_RESERVE: begin
                if (w_bad_arg) begin
                    o_res.status = bant_pkg::ST_BAD_ARG;
                end else if (w_unbound) begin
                    o_res.status = bant_pkg::ST_UNBOUND;
                end else if (!w_handle_ok) begin
                    o_res.status = bant_pkg::ST_BAD_TXN;
                end else if (w_ovf) begin
                    o_res.status = bant_pkg::ST_OVERFLOW;
                end else if (w_no_room) begin
                    o_res.status = bant_pkg::ST_NO_ROOM;
                end else begin
                    o_res.granted   = w_aligned;
                    o_res.coff      = i_cursor;
                    o_res.clen      = w_end[bant_pkg::WORD_W-1:0] - i_cursor;
                    o_upd.cursor_we = 1'b1;
                    o_upd.cursor    = w_end[bant_pkg::WORD_W-1:0];
                    o_upd.base_cur  = {1'b0, w_aligned}
                        + {{(bant_pkg::ADDR_W-bant_pkg::WORD_W+1){1'b0}}, i_item.count};
                end
            end
            bant_pkg::OP_COMMIT: begin
                if (w_unbound) begin
                    o_res.status = bant_pkg::ST_UNBOUND;
                end else if (!w_handle_ok) begin
                    o_res.status = bant_pkg::ST_BAD_TXN;
                end else begin
                    o_upd.mark_we   = 1'b1;
                    o_upd.mark      = i_cursor;
                    o_upd.stack.pop = 1'b1;
                end
            end
            bant_pkg::OP_ABANDON: begin
                if (w_unbound) begin
                    o_res.status = bant_pkg::ST_UNBOUND;
                end else if (!w_handle_ok) begin
                    o_res.status = bant_pkg::ST_BAD_TXN;
                end else begin
                    o_upd.stack.pop = 1'b1;
                    if (i_cursor > w_reclaim) begin
                        o_res.coff      = w_reclaim;
                        o_res.clen      = i_cursor - w_reclaim;
                        o_upd.cursor_we = 1'b1;
                        o_upd.cursor    = w_reclaim;
                        o_upd.base_cur  = {1'b0, i_base_addr}
                            + {{(bant_pkg::ADDR_W-bant_pkg::WORD_W+1){1'b0}}, w_reclaim};
                    end
                end
            end
            default: begin
                o_res.status = bant_pkg::ST_OK;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/bump_arena_nested_transactions.sv
// Item beats are held in the input register and results in the result register.
// Throughput: one item per cycle unless the result side stalls; each operation reads
// and updates cursor, mark and transaction stack as it leaves the input register.
// Reset (i_rst_n low at a clock edge) empties both stages and the stack, clears
// cursor, mark and registers, and sets the serial counter to one.
`default_nettype none
module bump_arena_nested_transactions (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bant_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bant_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bant_in_if.sink                                 i_item,
    bant_out_if.source                              o_result
);

    logic                         r_in_vld;
    bant_pkg::t_item              r_item;
    logic                         r_out_vld;
    bant_pkg::t_result            r_res;
    logic [bant_pkg::ADDR_W-1:0]  r_base_addr;
    logic [bant_pkg::WORD_W-1:0]  r_capacity;
    logic [bant_pkg::WORD_W-1:0]  r_cursor;
    logic [bant_pkg::WORD_W-1:0]  r_mark;
    logic [bant_pkg::WORD_W-1:0]  r_counter;
    logic [bant_pkg::ADDR_W:0]    r_base_cur;

    logic                         w_adv;
    logic                         w_fire;
    logic                         w_in_rdy;
    bant_pkg::t_result            w_res;
    bant_pkg::t_update            w_upd;
    bant_pkg::t_stack_cmd         w_stack_cmd;
    bant_pkg::t_stack_top         w_top;

    // Handshake: stage moves when the result register is free or being drained
    assign w_adv    = !r_out_vld || o_result.ready;
    assign w_fire   = r_in_vld && w_adv;
    assign w_in_rdy = !r_in_vld || w_adv;
    assign i_item.ready = w_in_rdy;

    // Capture input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_rdy) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_item.valid) begin
            r_item.op     <= bant_pkg::t_op'(i_item.operation);
            r_item.serial <= i_item.txn_serial;
            r_item.depth  <= i_item.txn_depth;
            r_item.count  <= i_item.byte_count;
            r_item.align  <= i_item.alignment;
        end
    end

    // Execute operation against current state
    bant_exec u_exec (
        .i_item      (r_item),
        .i_base_addr (r_base_addr),
        .i_capacity  (r_capacity),
        .i_cursor    (r_cursor),
        .i_mark      (r_mark),
        .i_counter   (r_counter),
        .i_base_cur  (r_base_cur),
        .i_top       (w_top),
        .o_res       (w_res),
        .o_upd       (w_upd)
    );

    // Gate stack changes by the fire strobe
    always_comb begin
        w_stack_cmd      = w_upd.stack;
        w_stack_cmd.push = w_upd.stack.push && w_fire;
        w_stack_cmd.pop  = w_upd.stack.pop && w_fire;
    end

    bant_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_stack_cmd),
        .o_top   (w_top)
    );

    // Apply configuration writes and operation updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= '0;
            r_capacity  <= '0;
            r_cursor    <= '0;
            r_mark      <= '0;
            r_counter   <= bant_pkg::WORD_W'(1);
            r_base_cur  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bant_pkg::CFG_BASE_ADDRESS: begin
                        r_base_addr <= i_cfg_data;
                        r_base_cur  <= {1'b0, i_cfg_data}
                            + {{(bant_pkg::ADDR_W-bant_pkg::WORD_W+1){1'b0}}, r_cursor};
                    end
                    bant_pkg::CFG_ARENA_CAPACITY: begin
                        r_capacity <= i_cfg_data[bant_pkg::WORD_W-1:0];
                    end
                    default: begin
                        r_capacity <= r_capacity;
                    end
                endcase
            end
            if (w_fire) begin
                if (w_upd.cursor_we) begin
                    r_cursor   <= w_upd.cursor;
                    r_base_cur <= w_upd.base_cur;
                end
                if (w_upd.mark_we) begin
                    r_mark <= w_upd.mark;
                end
                if (w_upd.counter_inc) begin
                    r_counter <= r_counter + bant_pkg::WORD_W'(1);
                end
            end
        end
    end

    // Hold result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    // Drive result channel
    assign o_result.valid           = r_out_vld;
    assign o_result.status          = r_res.status;
    assign o_result.granted_address = r_res.granted;
    assign o_result.new_serial      = r_res.nserial;
    assign o_result.new_depth       = r_res.ndepth;
    assign o_result.clear_offset    = r_res.coff;
    assign o_result.clear_length    = r_res.clen;

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_result.ready |=> r_out_vld && $stable(r_res))
        else $error("result register changed while stalled");

    a_state_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_cursor) && $stable(r_mark) && $stable(r_counter))
        else $error("state changed without an operation");

    a_fail_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_res.status != bant_pkg::ST_OK)
        |-> !w_upd.cursor_we && !w_upd.mark_we && !w_upd.counter_inc
            && !w_upd.stack.push && !w_upd.stack.pop)
        else $error("failed operation updated state");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bant_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bant_in_if  items_if ();
    bant_out_if results_if ();

    bump_arena_nested_transactions dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (items_if.sink),
        .o_result    (results_if.source)
    );

    // Directed rows: either a register write or an operation, with the result typed
    // in where it is obvious; the other rows are left to the arena predictor.
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [63:0]           reg_val;
        t_op                   op;
        logic [WORD_W-1:0]     serial;
        logic [DEPTH_W-1:0]    depth;
        logic [WORD_W-1:0]     count;
        logic [WORD_W-1:0]     align;
        bit                    typed;
        t_status               st;
        logic [WORD_W-1:0]     nserial;
        logic [DEPTH_W-1:0]    ndepth;
    } t_script_row;

    localparam int N_ROWS = 25;

    // Item rows carry CFG_BASE_ADDRESS only as a filler for the unused index
    t_script_row script [N_ROWS] = '{
        // unbound region after reset, argument checks come first
        '{0, CFG_BASE_ADDRESS, '0, OP_BEGIN, '0, '0, '0, '0, 1, ST_UNBOUND, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, '0, '0, '0, 32'd1, 1, ST_BAD_ARG, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, '0, '0, '1, '1, 1, ST_BAD_ARG, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, '0, '0, 32'd1, 32'd1, 1, ST_UNBOUND, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_ABANDON, '0, '0, '0, '0, 1, ST_UNBOUND, '0, '0},
        // bind a full-size region
        '{1, CFG_ARENA_CAPACITY, 64'hFFFF_FFFF, OP_BEGIN, '0, '0, '0, '0, 0, ST_OK, '0, '0},
        '{1, CFG_BASE_ADDRESS, 64'h1000, OP_BEGIN, '0, '0, '0, '0, 0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_COMMIT, '1, '1, '0, '0, 1, ST_BAD_TXN, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_BEGIN, '0, '0, '0, '0, 1, ST_OK, 32'd1, 4'd1},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, 32'd1, 4'd1, 32'd5, 32'd1, 0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_BEGIN, '0, '0, '0, '0, 1, ST_OK, 32'd2, 4'd2},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, 32'd2, 4'd2, 32'd16, 32'd16, 0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, 32'd7, 4'd2, 32'd1, 32'd1, 1, ST_BAD_TXN, '0, '0},
        // roll back the inner transaction, then commit the outer one
        '{0, CFG_BASE_ADDRESS, '0, OP_ABANDON, 32'd2, 4'd2, '0, '0, 0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_COMMIT, 32'd1, 4'd1, '0, '0, 1, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_BEGIN, '0, '0, '0, '0, 1, ST_OK, 32'd3, 4'd1},
        '{0, CFG_BASE_ADDRESS, '0, OP_ABANDON, 32'd3, 4'd1, '0, '0, 0, ST_OK, '0, '0},
        // region at the top of the address space
        '{1, CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFF0, OP_BEGIN, '0, '0, '0, '0,
          0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_BEGIN, '0, '0, '0, '0, 1, ST_OK, 32'd4, 4'd1},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, 32'd4, 4'd1, 32'd1, 32'h8000_0000,
          1, ST_OVERFLOW, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, 32'd4, 4'd1, '1, 32'd1, 1, ST_NO_ROOM, '0, '0},
        // shrink the region below the cursor
        '{1, CFG_ARENA_CAPACITY, 64'd2, OP_BEGIN, '0, '0, '0, '0, 0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_RESERVE, 32'd4, 4'd1, 32'd1, 32'd1, 1, ST_NO_ROOM, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_ABANDON, 32'd4, 4'd1, '0, '0, 0, ST_OK, '0, '0},
        '{0, CFG_BASE_ADDRESS, '0, OP_BEGIN, '0, '0, '0, '0, 1, ST_OK, 32'd5, 4'd1}
    };

    typedef struct {
        logic [63:0]       base;
        logic [WORD_W-1:0] cap;
        int                n_items;
        int                src_idle;
        int                rcv_idle;
        bit                long_hold;
    } t_phase;

    t_phase phases [5] = '{
        '{64'h0000_5A3C_9000_0000, 32'd4096,       240, 30, 53, 1'b0},
        '{64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 200, 53, 30, 1'b0},
        '{64'h0,                   32'd0,          30, 53, 30, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 32'd1,          40,  0,  0, 1'b0},
        '{64'h0,                   32'hFFFF_FFFF, 340,  0,  0, 1'b1}
    };

    // Arena state as the block should hold it
    logic [63:0]        reg_base;
    logic [WORD_W-1:0]  reg_cap;
    logic [WORD_W-1:0]  arn_cursor;
    logic [WORD_W-1:0]  arn_mark;
    logic [DEPTH_W-1:0] arn_depth;
    logic [WORD_W-1:0]  arn_serials [MAX_DEPTH];
    logic [WORD_W-1:0]  arn_bases [MAX_DEPTH];
    logic [WORD_W-1:0]  arn_next_serial;

    t_result pending_outcomes [$];
    int      errors;
    int      src_idle_pct;
    int      rcv_idle_pct;
    bit      hold_armed;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 100)
            $display("tb: %s mismatch: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit handle_ok(t_item it);
        if (arn_depth == 0 || it.depth != arn_depth)
            return 1'b0;
        return it.serial == arn_serials[arn_depth - 1];
    endfunction

    // Apply one operation to the arena state and return its result
    function automatic t_result arena_outcome(t_item it);
        t_result           r;
        logic [64:0]       start;
        logic [64:0]       bumped;
        logic [63:0]       mask;
        logic [63:0]       aligned;
        logic [63:0]       off;
        logic [63:0]       cap64;
        logic [WORD_W-1:0] floor_pt;
        r = '0;
        r.status = ST_OK;
        case (it.op)
            OP_BEGIN: begin
                if (reg_cap == 0) begin
                    r.status = ST_UNBOUND;
                end else if (arn_depth >= MAX_DEPTH) begin
                    r.status = ST_DEPTH_LIMIT;
                end else begin
                    r.nserial = arn_next_serial;
                    arn_serials[arn_depth] = arn_next_serial;
                    arn_bases[arn_depth] = arn_cursor;
                    arn_next_serial = arn_next_serial + 1;
                    arn_depth = arn_depth + 1;
                    r.ndepth = arn_depth;
                end
            end
            OP_RESERVE: begin
                if (it.count == 0 || it.align == 0 || (it.align & (it.align - 1)) != 0) begin
                    r.status = ST_BAD_ARG;
                end else if (reg_cap == 0) begin
                    r.status = ST_UNBOUND;
                end else if (!handle_ok(it)) begin
                    r.status = ST_BAD_TXN;
                end else begin
                    mask = {32'h0, it.align - 32'd1};
                    start = {1'b0, reg_base} + {33'h0, arn_cursor};
                    bumped = {1'b0, start[63:0]} + {1'b0, mask};
                    if (start[64] || bumped[64]) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        aligned = bumped[63:0] & ~mask;
                        off = aligned - reg_base;
                        cap64 = {32'h0, reg_cap};
                        if (off > cap64 || {32'h0, it.count} > cap64 - off) begin
                            r.status = ST_NO_ROOM;
                        end else begin
                            r.granted = aligned;
                            r.coff = arn_cursor;
                            r.clen = off[31:0] + it.count - arn_cursor;
                            arn_cursor = off[31:0] + it.count;
                        end
                    end
                end
            end
            default: begin
                if (reg_cap == 0) begin
                    r.status = ST_UNBOUND;
                end else if (!handle_ok(it)) begin
                    r.status = ST_BAD_TXN;
                end else begin
                    if (it.op == OP_COMMIT) begin
                        arn_mark = arn_cursor;
                    end else begin
                        // roll back no further than the committed mark
                        floor_pt = arn_bases[arn_depth - 1];
                        if (arn_mark > floor_pt)
                            floor_pt = arn_mark;
                        if (arn_cursor > floor_pt) begin
                            r.coff = floor_pt;
                            r.clen = arn_cursor - floor_pt;
                            arn_cursor = floor_pt;
                        end
                    end
                    arn_depth = arn_depth - 1;
                    arn_serials[arn_depth] = '0;
                    arn_bases[arn_depth] = '0;
                end
            end
        endcase
        return r;
    endfunction

    // Mostly well-formed operations on the open transaction, plus some noise
    function automatic t_item next_random_item();
        t_item it;
        int    pick;
        int    k;
        pick = $urandom_range(0, 99);
        it.serial = $urandom;
        it.depth = 4'($urandom_range(0, 15));
        it.count = $urandom;
        it.align = $urandom;
        if (pick < 28)
            it.op = OP_BEGIN;
        else if (pick < 63)
            it.op = OP_RESERVE;
        else if (pick < 79)
            it.op = OP_COMMIT;
        else if (pick < 94)
            it.op = OP_ABANDON;
        else
            it.op = t_op'($urandom_range(0, 3));
        if (pick < 94) begin
            if (arn_depth != 0 && $urandom_range(0, 99) < 85) begin
                it.serial = arn_serials[arn_depth - 1];
                it.depth = arn_depth;
            end
            k = $urandom_range(0, 99);
            if (k >= 6)
                it.count = 32'($urandom_range(1, 64));
            else if (k >= 3)
                it.count = '0;
            k = $urandom_range(0, 99);
            if (k >= 12)
                it.align = 32'd1 << $urandom_range(0, 6);
            else if (k >= 7)
                it.align = 32'd1 << $urandom_range(7, 31);
            else if (k >= 4)
                it.align = '0;
        end
        return it;
    endfunction

    // Offer one beat, with random gaps ahead of it, and hold it until taken
    task automatic send(t_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            items_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        items_if.valid      <= 1'b1;
        items_if.operation  <= it.op;
        items_if.txn_serial <= it.serial;
        items_if.txn_depth  <= it.depth;
        items_if.byte_count <= it.count;
        items_if.alignment  <= it.align;
        @(posedge i_clk);
        while (!items_if.ready)
            @(posedge i_clk);
    endtask

    task automatic send_predicted(t_item it);
        pending_outcomes.push_back(arena_outcome(it));
        send(it);
    endtask

    // Write a register once every outstanding result is back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        items_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_BASE_ADDRESS)
            reg_base = val;
        else
            reg_cap = val[WORD_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: check each accepted beat, then pick the next ready value
    initial begin : result_side
        t_result got;
        t_result want;
        bit      hold_taken;
        int      hold_left;
        hold_taken = 1'b0;
        hold_left = 0;
        results_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && results_if.valid && results_if.ready) begin
                got.status  = t_status'(results_if.status);
                got.granted = results_if.granted_address;
                got.nserial = results_if.new_serial;
                got.ndepth  = results_if.new_depth;
                got.coff    = results_if.clear_offset;
                got.clen    = results_if.clear_length;
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got.status), '0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.granted !== want.granted)
                        report_mismatch("granted_address", got.granted, want.granted);
                    if (got.nserial !== want.nserial)
                        report_mismatch("new_serial", 64'(got.nserial), 64'(want.nserial));
                    if (got.ndepth !== want.ndepth)
                        report_mismatch("new_depth", 64'(got.ndepth), 64'(want.ndepth));
                    if (got.coff !== want.coff)
                        report_mismatch("clear_offset", 64'(got.coff), 64'(want.coff));
                    if (got.clen !== want.clen)
                        report_mismatch("clear_length", 64'(got.clen), 64'(want.clen));
                end
            end
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 48;
            end
            if (hold_left != 0) begin
                hold_left--;
                results_if.ready <= 1'b0;
            end else begin
                results_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    initial begin : item_side
        t_item it;
        t_result want;
        int wait_cycles;
        errors = 0;
        src_idle_pct = 0;
        rcv_idle_pct <= 0;
        hold_armed <= 1'b0;
        reg_base = '0;
        reg_cap = '0;
        arn_cursor = '0;
        arn_mark = '0;
        arn_depth = '0;
        arn_next_serial = 32'd1;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            arn_serials[i] = '0;
            arn_bases[i] = '0;
        end
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_BASE_ADDRESS;
        i_cfg_data  <= '0;
        items_if.valid      <= 1'b0;
        items_if.operation  <= OP_BEGIN;
        items_if.txn_serial <= '0;
        items_if.txn_depth  <= '0;
        items_if.byte_count <= '0;
        items_if.alignment  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, run with the first idling mix
        src_idle_pct = phases[0].src_idle;
        rcv_idle_pct <= phases[0].rcv_idle;
        foreach (script[i]) begin
            if (script[i].is_reg) begin
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                it.op = script[i].op;
                it.serial = script[i].serial;
                it.depth = script[i].depth;
                it.count = script[i].count;
                it.align = script[i].align;
                want = arena_outcome(it);
                if (script[i].typed)
                    want = '{status: script[i].st, nserial: script[i].nserial,
                             ndepth: script[i].ndepth, default: '0};
                pending_outcomes.push_back(want);
                send(it);
            end
        end

        // Random phases, each under its own region setting and idling mix
        foreach (phases[p]) begin
            write_reg(CFG_BASE_ADDRESS, phases[p].base);
            write_reg(CFG_ARENA_CAPACITY, {32'h0, phases[p].cap});
            src_idle_pct = phases[p].src_idle;
            rcv_idle_pct <= phases[p].rcv_idle;
            if (phases[p].long_hold)
                hold_armed <= 1'b1;
            repeat (phases[p].n_items)
                send_predicted(next_random_item());
        end
        items_if.valid <= 1'b0;

        // Drain, then let the pipeline settle
        wait_cycles = 0;
        while (pending_outcomes.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("missing results", 64'(pending_outcomes.size()), '0);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
